// ===== src/cslex_pkg.sv =====
// cslex_pkg: shared types, token and error codes, keyword table and helpers
// for the c subset lexer. Used by cslex_scan, cslex_rsp_buf and
// c_subset_lexer_unit. No dependencies.
package cslex_pkg;

   localparam int OFF_BITS = 20;
   localparam logic [OFF_BITS-1:0] OFF_MAX = {OFF_BITS{1'b1}};

   // token kinds
   localparam logic [4:0] KIND_IDENT   = 5'd0;
   localparam logic [4:0] KIND_INT     = 5'd1;
   localparam logic [4:0] KIND_KW      = 5'd2;
   localparam logic [4:0] KIND_OPENPA  = 5'd11;
   localparam logic [4:0] KIND_CLOSEPA = 5'd12;
   localparam logic [4:0] KIND_OPENBR  = 5'd13;
   localparam logic [4:0] KIND_CLOSEBR = 5'd14;
   localparam logic [4:0] KIND_COMMA   = 5'd15;
   localparam logic [4:0] KIND_SEMI    = 5'd16;
   localparam logic [4:0] KIND_ASSIGN  = 5'd17;
   localparam logic [4:0] KIND_EQEQ    = 5'd18;
   localparam logic [4:0] KIND_NEQ     = 5'd19;
   localparam logic [4:0] KIND_LT      = 5'd20;
   localparam logic [4:0] KIND_LE      = 5'd21;
   localparam logic [4:0] KIND_GT      = 5'd22;
   localparam logic [4:0] KIND_GE      = 5'd23;
   localparam logic [4:0] KIND_PLUS    = 5'd24;
   localparam logic [4:0] KIND_MINUS   = 5'd25;
   localparam logic [4:0] KIND_STAR    = 5'd26;
   localparam logic [4:0] KIND_SLASH   = 5'd27;
   localparam logic [4:0] KIND_PERCENT = 5'd28;
   localparam logic [4:0] KIND_EOF     = 5'd29;

   // error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_ILLEGAL = 2'd1;
   localparam logic [1:0] ERR_OCTAL   = 2'd2;
   localparam logic [1:0] ERR_LETTER  = 2'd3;

   localparam int KW_COUNT = 9;
   localparam int KW_CHARS = 6;

   // keywords left-aligned, zero padded to six characters
   localparam logic [8*KW_CHARS-1:0] KW_WORD [KW_COUNT] = '{
      {"void", 16'h0}, {"int", 24'h0}, {"if", 32'h0}, {"else", 16'h0},
      {"while", 8'h0}, {"for", 24'h0}, {"do", 32'h0}, "return",
      {"print", 8'h0}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd4, 3'd3, 3'd2, 3'd4, 3'd5, 3'd3, 3'd2, 3'd6, 3'd5
   };

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_IDENT, MODE_ZERO, MODE_DEC, MODE_OCT, MODE_HEX,
      MODE_EQ, MODE_BANG, MODE_LT, MODE_GT, MODE_SLASH, MODE_COMMENT
   } mode_type;

   typedef struct packed {
      logic [4:0]          kind;
      logic [OFF_BITS-1:0] start;
      logic [OFF_BITS-1:0] len;
      logic [OFF_BITS-1:0] line;
      logic [1:0]          err;
      logic                last;
   } result_type;

   // up to three tokens produced by one request
   typedef struct packed {
      result_type [2:0] res;
      logic [1:0]       cnt;
   } batch_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction

   function automatic logic [OFF_BITS-1:0] sat_inc(input logic [OFF_BITS-1:0] x);
      return (x == OFF_MAX) ? x : x + 1'b1;
   endfunction

   function automatic result_type mk_res(input logic [4:0] kind,
                                         input logic [OFF_BITS-1:0] start,
                                         input logic [OFF_BITS-1:0] len,
                                         input logic [OFF_BITS-1:0] line,
                                         input logic [1:0] err,
                                         input logic last);
      result_type r;
      r.kind  = kind;
      r.start = start;
      r.len   = len;
      r.line  = line;
      r.err   = err;
      r.last  = last;
      return r;
   endfunction

   // parallel match of the held identifier prefix against all keywords
   function automatic logic [4:0] kw_kind(input logic [KW_CHARS-1:0][7:0] kbuf,
                                          input logic [2:0] klen);
      logic [8*KW_CHARS-1:0] word;
      logic [4:0]            kind;
      kind = KIND_IDENT;
      word = '0;
      for (int i = 0; i < KW_CHARS; i++) begin
         word[8*KW_CHARS-1-8*i -: 8] = (3'(i) < klen) ? kbuf[i] : 8'h00;
      end
      for (int k = 0; k < KW_COUNT; k++) begin
         if (klen == KW_LEN[k] && word == KW_WORD[k]) begin
            kind = KIND_KW + 5'(k);
         end
      end
      return kind;
   endfunction

endpackage

// ===== src/cslex_scan.sv =====
// cslex_scan: scanner state and the combinational step that turns one byte
// into up to three tokens. Depends on cslex_pkg.
module cslex_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           ch,
   input  logic                 fin,
   output cslex_pkg::batch_type batch
);

   localparam logic [cslex_pkg::OFF_BITS-1:0] LEN_ONE = cslex_pkg::OFF_BITS'(1);
   localparam logic [cslex_pkg::OFF_BITS-1:0] LEN_TWO = cslex_pkg::OFF_BITS'(2);

   cslex_pkg::mode_type              mode_ff, mode_in;
   logic [cslex_pkg::OFF_BITS-1:0]   tok_ff, tok_in;
   logic [cslex_pkg::OFF_BITS-1:0]   off_ff, off_in;
   logic [cslex_pkg::OFF_BITS-1:0]   line_ff, line_in;
   logic [cslex_pkg::KW_CHARS-1:0][7:0] kwbuf_ff, kwbuf_in;
   logic [2:0]                       idlen_ff, idlen_in;
   logic                             errh_ff, errh_in;

   cslex_pkg::result_type            cand [4];
   logic [3:0]                       cand_vld;
   logic                             again;
   logic [4:0]                       k1;
   logic [cslex_pkg::OFF_BITS-1:0]   span, span1, flen;
   logic [1:0]                       n;

   always_comb begin
      mode_in  = mode_ff;
      tok_in   = tok_ff;
      off_in   = off_ff;
      line_in  = line_ff;
      kwbuf_in = kwbuf_ff;
      idlen_in = idlen_ff;
      errh_in  = errh_ff;
      cand_vld = '0;
      for (int i = 0; i < 4; i++) begin
         cand[i] = '0;
      end
      again = 1'b0;
      k1    = cslex_pkg::KIND_ASSIGN;
      span  = off_ff - tok_ff;
      span1 = cslex_pkg::sat_inc(span);
      flen  = '0;

      if (!errh_ff) begin
         again = (mode_ff == cslex_pkg::MODE_IDLE);

         // byte that continues or closes a pending token
         if (!again) begin
            unique case (mode_ff)
               cslex_pkg::MODE_IDENT: begin
                  if (cslex_pkg::is_letter(ch) || cslex_pkg::is_digit(ch)) begin
                     if (idlen_ff < 3'd6) kwbuf_in[idlen_ff] = ch;
                     if (idlen_ff != 3'd7) idlen_in = idlen_ff + 3'd1;
                  end else begin
                     cand_vld[0] = 1'b1;
                     cand[0] = cslex_pkg::mk_res(cslex_pkg::kw_kind(kwbuf_ff, idlen_ff),
                                                 tok_ff, span, line_ff,
                                                 cslex_pkg::ERR_NONE, 1'b0);
                     again = 1'b1;
                  end
               end
               cslex_pkg::MODE_ZERO, cslex_pkg::MODE_DEC,
               cslex_pkg::MODE_OCT, cslex_pkg::MODE_HEX: begin
                  priority if (mode_ff == cslex_pkg::MODE_ZERO && ch == "x") begin
                     mode_in = cslex_pkg::MODE_HEX;
                  end else if ((mode_ff == cslex_pkg::MODE_ZERO ||
                                mode_ff == cslex_pkg::MODE_OCT) &&
                               (ch == "8" || ch == "9")) begin
                     errh_in = 1'b1;
                     mode_in = cslex_pkg::MODE_IDLE;
                     cand_vld[0] = 1'b1;
                     cand[0] = cslex_pkg::mk_res(cslex_pkg::KIND_IDENT, tok_ff, span1,
                                                 line_ff, cslex_pkg::ERR_OCTAL, 1'b1);
                  end else if (mode_ff == cslex_pkg::MODE_HEX ? cslex_pkg::is_hex(ch)
                                                              : cslex_pkg::is_digit(ch))
                  begin
                     if (mode_ff == cslex_pkg::MODE_ZERO) mode_in = cslex_pkg::MODE_OCT;
                  end else if (cslex_pkg::is_letter(ch)) begin
                     errh_in = 1'b1;
                     mode_in = cslex_pkg::MODE_IDLE;
                     cand_vld[0] = 1'b1;
                     cand[0] = cslex_pkg::mk_res(cslex_pkg::KIND_IDENT, tok_ff, span1,
                                                 line_ff, cslex_pkg::ERR_LETTER, 1'b1);
                  end else begin
                     cand_vld[0] = 1'b1;
                     cand[0] = cslex_pkg::mk_res(cslex_pkg::KIND_INT, tok_ff, span,
                                                 line_ff, cslex_pkg::ERR_NONE, 1'b0);
                     again = 1'b1;
                  end
               end
               cslex_pkg::MODE_EQ, cslex_pkg::MODE_LT, cslex_pkg::MODE_GT: begin
                  unique case (mode_ff)
                     cslex_pkg::MODE_LT: k1 = cslex_pkg::KIND_LT;
                     cslex_pkg::MODE_GT: k1 = cslex_pkg::KIND_GT;
                     default:            k1 = cslex_pkg::KIND_ASSIGN;
                  endcase
                  cand_vld[0] = 1'b1;
                  if (ch == "=") begin
                     mode_in = cslex_pkg::MODE_IDLE;
                     cand[0] = cslex_pkg::mk_res(k1 + 5'd1, tok_ff, LEN_TWO, line_ff,
                                                 cslex_pkg::ERR_NONE, 1'b0);
                  end else begin
                     cand[0] = cslex_pkg::mk_res(k1, tok_ff, LEN_ONE, line_ff,
                                                 cslex_pkg::ERR_NONE, 1'b0);
                     again = 1'b1;
                  end
               end
               cslex_pkg::MODE_BANG: begin
                  cand_vld[0] = 1'b1;
                  mode_in = cslex_pkg::MODE_IDLE;
                  if (ch == "=") begin
                     cand[0] = cslex_pkg::mk_res(cslex_pkg::KIND_NEQ, tok_ff, LEN_TWO,
                                                 line_ff, cslex_pkg::ERR_NONE, 1'b0);
                  end else begin
                     errh_in = 1'b1;
                     cand[0] = cslex_pkg::mk_res(cslex_pkg::KIND_IDENT, tok_ff, LEN_ONE,
                                                 line_ff, cslex_pkg::ERR_ILLEGAL, 1'b1);
                  end
               end
               cslex_pkg::MODE_SLASH: begin
                  if (ch == "/") begin
                     mode_in = cslex_pkg::MODE_COMMENT;
                  end else begin
                     cand_vld[0] = 1'b1;
                     cand[0] = cslex_pkg::mk_res(cslex_pkg::KIND_SLASH, tok_ff, LEN_ONE,
                                                 line_ff, cslex_pkg::ERR_NONE, 1'b0);
                     again = 1'b1;
                  end
               end
               cslex_pkg::MODE_COMMENT: begin
                  // newline ends the comment and is then scanned as a line break
                  if (ch == 8'h0A) again = 1'b1;
               end
               default: again = 1'b1;
            endcase
            if (again) mode_in = cslex_pkg::MODE_IDLE;
         end

         // byte scanned from idle
         if (again && !errh_in) begin
            priority if (cslex_pkg::is_letter(ch)) begin
               mode_in     = cslex_pkg::MODE_IDENT;
               tok_in      = off_ff;
               kwbuf_in[0] = ch;
               idlen_in    = 3'd1;
            end else if (cslex_pkg::is_digit(ch)) begin
               mode_in = (ch == "0") ? cslex_pkg::MODE_ZERO : cslex_pkg::MODE_DEC;
               tok_in  = off_ff;
            end else begin
               cand[1] = cslex_pkg::mk_res(cslex_pkg::KIND_IDENT, off_ff, LEN_ONE,
                                           line_ff, cslex_pkg::ERR_NONE, 1'b0);
               unique case (ch)
                  8'h0A: line_in = cslex_pkg::sat_inc(line_ff);
                  " ", 8'h09, 8'h0D: ;
                  "(": begin cand_vld[1] = 1'b1; cand[1].kind = cslex_pkg::KIND_OPENPA;  end
                  ")": begin cand_vld[1] = 1'b1; cand[1].kind = cslex_pkg::KIND_CLOSEPA; end
                  "{": begin cand_vld[1] = 1'b1; cand[1].kind = cslex_pkg::KIND_OPENBR;  end
                  "}": begin cand_vld[1] = 1'b1; cand[1].kind = cslex_pkg::KIND_CLOSEBR; end
                  ",": begin cand_vld[1] = 1'b1; cand[1].kind = cslex_pkg::KIND_COMMA;   end
                  ";": begin cand_vld[1] = 1'b1; cand[1].kind = cslex_pkg::KIND_SEMI;    end
                  "+": begin cand_vld[1] = 1'b1; cand[1].kind = cslex_pkg::KIND_PLUS;    end
                  "-": begin cand_vld[1] = 1'b1; cand[1].kind = cslex_pkg::KIND_MINUS;   end
                  "*": begin cand_vld[1] = 1'b1; cand[1].kind = cslex_pkg::KIND_STAR;    end
                  "%": begin cand_vld[1] = 1'b1; cand[1].kind = cslex_pkg::KIND_PERCENT; end
                  "=": begin mode_in = cslex_pkg::MODE_EQ;    tok_in = off_ff; end
                  "!": begin mode_in = cslex_pkg::MODE_BANG;  tok_in = off_ff; end
                  "<": begin mode_in = cslex_pkg::MODE_LT;    tok_in = off_ff; end
                  ">": begin mode_in = cslex_pkg::MODE_GT;    tok_in = off_ff; end
                  "/": begin mode_in = cslex_pkg::MODE_SLASH; tok_in = off_ff; end
                  default: begin
                     errh_in      = 1'b1;
                     cand_vld[1]  = 1'b1;
                     cand[1].err  = cslex_pkg::ERR_ILLEGAL;
                     cand[1].last = 1'b1;
                  end
               endcase
            end
         end

         // last byte: flush the pending token, then end-of-file
         if (fin && !errh_in) begin
            flen = cslex_pkg::sat_inc(off_ff) - tok_in;
            cand[2] = cslex_pkg::mk_res(cslex_pkg::KIND_INT, tok_in, LEN_ONE, line_in,
                                        cslex_pkg::ERR_NONE, 1'b0);
            unique case (mode_in)
               cslex_pkg::MODE_IDENT: begin
                  cand_vld[2] = 1'b1;
                  cand[2].kind = cslex_pkg::kw_kind(kwbuf_in, idlen_in);
                  cand[2].len  = flen;
               end
               cslex_pkg::MODE_ZERO, cslex_pkg::MODE_DEC,
               cslex_pkg::MODE_OCT, cslex_pkg::MODE_HEX: begin
                  cand_vld[2] = 1'b1;
                  cand[2].len = flen;
               end
               cslex_pkg::MODE_EQ: begin
                  cand_vld[2] = 1'b1; cand[2].kind = cslex_pkg::KIND_ASSIGN;
               end
               cslex_pkg::MODE_LT: begin
                  cand_vld[2] = 1'b1; cand[2].kind = cslex_pkg::KIND_LT;
               end
               cslex_pkg::MODE_GT: begin
                  cand_vld[2] = 1'b1; cand[2].kind = cslex_pkg::KIND_GT;
               end
               cslex_pkg::MODE_SLASH: begin
                  cand_vld[2] = 1'b1; cand[2].kind = cslex_pkg::KIND_SLASH;
               end
               cslex_pkg::MODE_BANG: begin
                  errh_in      = 1'b1;
                  cand_vld[2]  = 1'b1;
                  cand[2].kind = cslex_pkg::KIND_IDENT;
                  cand[2].err  = cslex_pkg::ERR_ILLEGAL;
                  cand[2].last = 1'b1;
               end
               default: ;
            endcase
            if (!errh_in) begin
               cand_vld[3] = 1'b1;
               cand[3] = cslex_pkg::mk_res(cslex_pkg::KIND_EOF,
                                           cslex_pkg::sat_inc(off_ff), '0, line_in,
                                           cslex_pkg::ERR_NONE, 1'b1);
            end
         end
      end

      // last byte restarts the scanner for the next text
      if (fin) begin
         mode_in  = cslex_pkg::MODE_IDLE;
         tok_in   = '0;
         off_in   = '0;
         line_in  = cslex_pkg::OFF_BITS'(1);
         idlen_in = '0;
         errh_in  = 1'b0;
      end else begin
         off_in = cslex_pkg::sat_inc(off_ff);
      end
   end

   // pack the produced tokens in order
   always_comb begin
      batch = '0;
      n     = '0;
      for (int i = 0; i < 4; i++) begin
         if (cand_vld[i] && n != 2'd3) begin
            batch.res[n] = cand[i];
            n = n + 2'd1;
         end
      end
      batch.cnt = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= cslex_pkg::MODE_IDLE;
         tok_ff   <= '0;
         off_ff   <= '0;
         line_ff  <= cslex_pkg::OFF_BITS'(1);
         idlen_ff <= '0;
         errh_ff  <= 1'b0;
      end else if (step_en) begin
         mode_ff  <= mode_in;
         tok_ff   <= tok_in;
         off_ff   <= off_in;
         line_ff  <= line_in;
         idlen_ff <= idlen_in;
         errh_ff  <= errh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) kwbuf_ff <= kwbuf_in;
   end

endmodule

// ===== src/cslex_rsp_buf.sv =====
// cslex_rsp_buf: three-entry result register that holds the tokens of one
// request and hands one out per cycle unless rsp stalls. Uses cslex_pkg.
module cslex_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  cslex_pkg::batch_type  batch,
   output logic                  can_load,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output cslex_pkg::result_type rsp_res
);

   cslex_pkg::result_type ent_ff [3];
   logic [1:0]            cnt_ff;
   logic                  pop;

   assign pop        = (cnt_ff != 2'd0) && rsp_tready;
   // free now, or the last held token leaves this cycle
   assign can_load   = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_tready);
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_res    = ent_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= batch.cnt;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff[0] <= batch.res[0];
         ent_ff[1] <= batch.res[1];
         ent_ff[2] <= batch.res[2];
      end else if (pop) begin
         ent_ff[0] <= ent_ff[1];
         ent_ff[1] <= ent_ff[2];
      end
   end

endmodule

// ===== src/c_subset_lexer_unit.sv =====
// c_subset_lexer_unit: streaming tokenizer for a small c-like language.
// Uses cslex_pkg, cslex_scan and cslex_rsp_buf.
//
// The req channel takes one source byte per request; req_tlast marks the
// last byte of a text. The rsp channel returns tokens (kind, start offset,
// length, line, error code); rsp_tlast is set on end-of-file and on an error
// token. One byte gives zero to three tokens.
// A request is registered in the input register, scanned once the result
// register can take its batch, and its tokens land in that three-entry
// result register, from which the first token of a byte shows on rsp.
// A new byte is taken every cycle as long as each byte yields at most one
// token and rsp_tready stays high; a byte with more tokens holds the
// scanner while they drain one per cycle.
// A rsp stall holds the result register and, once it cannot take the next
// batch, the input register and req_tready.
// Reset clears the scanner to the start of a text (offset 0, line 1) and
// empties both registers. After an error token, bytes yield nothing until
// the last byte, which restarts the scanner.
module c_subset_lexer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [4:0] token_kind, [24:5] start_offset,
                                    // [44:25] token_length, [64:45] line_number,
                                    // [66:65] error_code, rest zero
   output logic        rsp_tlast    // last_result
);

   logic                  in_vld_ff;
   logic [7:0]            in_byte_ff;
   logic                  in_fin_ff;
   logic                  can_load;
   logic                  step_en;
   cslex_pkg::batch_type  batch;
   cslex_pkg::result_type rsp_res;

   assign step_en    = in_vld_ff && can_load;
   assign req_tready = !in_vld_ff || step_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_vld_ff <= 1'b1;
      end else if (step_en) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_fin_ff  <= req_tlast;
      end
   end

   cslex_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .ch      (in_byte_ff),
      .fin     (in_fin_ff),
      .batch   (batch)
   );

   cslex_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (step_en),
      .batch      (batch),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tdata = {5'b0, rsp_res.err, rsp_res.line, rsp_res.len,
                       rsp_res.start, rsp_res.kind};
   assign rsp_tlast = rsp_res.last;

endmodule
